>>> hdl/particulate_sensor_frame_parser_top_macros.svh
// assertion macros for the particulate sensor frame parser
// no dependencies; included by the modules that carry assertions
`ifndef PARTICULATE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define PARTICULATE_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PSFP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, disabled during reset
`define PSFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSFP_ASSERT_NOW(label, clk, rst, ante, cons)
`define PSFP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hdl/psfp_pkg.sv
// shared types and constants for the particulate sensor frame parser
// no dependencies; used by the channel interfaces and the top level
package psfp_pkg;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_CSUM_ERR    = 2'd1,
    STATUS_FRAMING_ERR = 2'd2
  } status_t;

  // frame format register codes
  localparam logic FMT_LONG  = 1'b0;
  localparam logic FMT_SHORT = 1'b1;

  // frame lengths in bytes
  localparam logic [5:0] LEN_LONG  = 6'd32;
  localparam logic [5:0] LEN_SHORT = 6'd10;

  // framing bytes, long format
  localparam logic [7:0] LONG_HDR0 = 8'h42;
  localparam logic [7:0] LONG_HDR1 = 8'h4D;

  // framing bytes, short format
  localparam logic [7:0] SHORT_HDR0 = 8'hAA;
  localparam logic [7:0] SHORT_HDR1 = 8'hC0;
  localparam logic [7:0] SHORT_TAIL = 8'hAB;

  localparam int SUM_W  = 13;
  localparam int RAW_W  = 16;
  localparam int PM_W   = 20;

endpackage

>>> hdl/psfp_channels.sv
// valid/ready channel interfaces for the particulate sensor frame parser
// depends on psfp_pkg
interface psfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_start;

  modport source (output valid, output rx_byte, output burst_start, input ready);
  modport sink (input valid, input rx_byte, input burst_start, output ready);
endinterface

interface psfp_out_if;
  import psfp_pkg::*;
  logic             valid;
  logic             ready;
  status_t          status;
  logic [PM_W-1:0]  pm25_tenths;
  logic [PM_W-1:0]  pm10_tenths;

  modport source (output valid, output status, output pm25_tenths, output pm10_tenths,
                  input ready);
  modport sink (input valid, input status, input pm25_tenths, input pm10_tenths,
                output ready);
endinterface

interface psfp_cfg_if;
  logic valid;
  logic ready;
  logic frame_format;

  modport source (output valid, output frame_format, input ready);
  modport sink (input valid, input frame_format, output ready);
endinterface

>>> hdl/particulate_sensor_frame_parser_top.sv
// particulate sensor frame parser: byte-wise frame capture, checksum and scaling
// depends on psfp_pkg, the channel interfaces and the assertion macros header
//
//   channel   dir  payload                                 transaction
//   in_ch     in   rx_byte[7:0], burst_start               one received byte
//   out_ch    out  status[1:0], pm25_tenths, pm10_tenths   one frame result
//   cfg_ch    in   frame_format                            register write
//
// one byte per cycle while in_ch is not stalled; a frame result is registered in the output
// register in the cycle after its last byte is taken, set by the single parse stage
// rst is synchronous: position, sum, flags and format clear, framing_ok sets
// in_ch stalls only while a result sits in the output register and out_ch.ready is low
// cfg_ch is always ready
`include "particulate_sensor_frame_parser_top_macros.svh"

module particulate_sensor_frame_parser_top (
  input  logic clk,
  input  logic rst,
  psfp_in_if.sink    in_ch,
  psfp_out_if.source out_ch,
  psfp_cfg_if.sink   cfg_ch
);
  import psfp_pkg::*;

  // frame state
  logic             frame_format;
  logic [5:0]       byte_position;
  logic [SUM_W-1:0] running_sum;
  logic             framing_ok;
  logic [7:0]       checksum_high;
  logic [RAW_W-1:0] pm25_raw;
  logic [RAW_W-1:0] pm10_raw;
  logic             frame_done;

  logic [5:0]       byte_position_next;
  logic [SUM_W-1:0] running_sum_next;
  logic             framing_ok_next;
  logic [7:0]       checksum_high_next;
  logic [RAW_W-1:0] pm25_raw_next;
  logic [RAW_W-1:0] pm10_raw_next;
  logic             frame_done_next;

  // result register
  logic             out_valid;
  status_t          out_status;
  logic [PM_W-1:0]  out_pm25;
  logic [PM_W-1:0]  out_pm10;

  logic             emit;
  status_t          status_next;
  logic [PM_W-1:0]  pm25_next;
  logic [PM_W-1:0]  pm10_next;

  logic             in_fire;
  logic [7:0]       b;
  logic [5:0]       pos;
  logic [SUM_W-1:0] sum_eff;
  logic [SUM_W-1:0] sum_add;
  logic             fok_eff;
  logic             skip;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_status;
  assign out_ch.pm25_tenths = out_pm25;
  assign out_ch.pm10_tenths = out_pm10;

  // burst start restarts capture before the byte is judged
  assign pos     = in_ch.burst_start ? 6'd0 : byte_position;
  assign sum_eff = in_ch.burst_start ? '0 : running_sum;
  assign fok_eff = in_ch.burst_start ? 1'b1 : framing_ok;
  assign sum_add = sum_eff + {{(SUM_W-8){1'b0}}, b};
  assign skip    = (!in_ch.burst_start && frame_done) ||
                   (pos >= ((frame_format == FMT_SHORT) ? LEN_SHORT : LEN_LONG));

  // per-byte parse
  always_comb begin
    byte_position_next = pos;
    running_sum_next   = sum_eff;
    framing_ok_next    = fok_eff;
    checksum_high_next = checksum_high;
    pm25_raw_next      = pm25_raw;
    pm10_raw_next      = pm10_raw;
    frame_done_next    = in_ch.burst_start ? 1'b0 : frame_done;
    emit               = 1'b0;
    status_next        = STATUS_OK;
    if (!skip) begin
      byte_position_next = pos + 6'd1;
      if (frame_format == FMT_LONG) begin
        if (pos == 6'd0 && b != LONG_HDR0) framing_ok_next = 1'b0;
        if (pos == 6'd1 && b != LONG_HDR1) framing_ok_next = 1'b0;
        if (pos < 6'd30) running_sum_next = sum_add;
        if (pos == 6'd6) pm10_raw_next[15:8] = b;
        if (pos == 6'd7) pm10_raw_next[7:0]  = b;
        if (pos == 6'd8) pm25_raw_next[15:8] = b;
        if (pos == 6'd9) pm25_raw_next[7:0]  = b;
        if (pos == 6'd30) checksum_high_next = b;
        if (pos == 6'd31) begin
          frame_done_next = 1'b1;
          emit            = 1'b1;
          if (!fok_eff) status_next = STATUS_FRAMING_ERR;
          else if ({3'b000, sum_eff} != {checksum_high, b}) status_next = STATUS_CSUM_ERR;
        end
      end else begin
        if (pos == 6'd0 && b != SHORT_HDR0) framing_ok_next = 1'b0;
        if (pos == 6'd1 && b != SHORT_HDR1) framing_ok_next = 1'b0;
        if (pos >= 6'd2 && pos < 6'd8) running_sum_next = sum_add;
        if (pos == 6'd2) pm25_raw_next[7:0]  = b;
        if (pos == 6'd3) pm25_raw_next[15:8] = b;
        if (pos == 6'd4) pm10_raw_next[7:0]  = b;
        if (pos == 6'd5) pm10_raw_next[15:8] = b;
        if (pos == 6'd8) checksum_high_next = b;
        if (pos == 6'd9) begin
          if (b != SHORT_TAIL) framing_ok_next = 1'b0;
          frame_done_next = 1'b1;
          emit            = 1'b1;
          if (!framing_ok_next) status_next = STATUS_FRAMING_ERR;
          else if (sum_eff[7:0] != checksum_high) status_next = STATUS_CSUM_ERR;
        end
      end
    end
  end

  // readings: long format scaled by ten (x*8 + x*2), zero unless ok
  always_comb begin
    pm25_next = '0;
    pm10_next = '0;
    if (status_next == STATUS_OK) begin
      if (frame_format == FMT_LONG) begin
        pm25_next = ({{(PM_W-RAW_W){1'b0}}, pm25_raw} << 3) +
                    ({{(PM_W-RAW_W){1'b0}}, pm25_raw} << 1);
        pm10_next = ({{(PM_W-RAW_W){1'b0}}, pm10_raw} << 3) +
                    ({{(PM_W-RAW_W){1'b0}}, pm10_raw} << 1);
      end else begin
        pm25_next = {{(PM_W-RAW_W){1'b0}}, pm25_raw};
        pm10_next = {{(PM_W-RAW_W){1'b0}}, pm10_raw};
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format <= FMT_LONG;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      frame_format <= cfg_ch.frame_format;
    end
  end

  // frame state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      running_sum   <= '0;
      framing_ok    <= 1'b1;
      checksum_high <= '0;
      pm25_raw      <= '0;
      pm10_raw      <= '0;
      frame_done    <= 1'b0;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
      framing_ok    <= framing_ok_next;
      checksum_high <= checksum_high_next;
      pm25_raw      <= pm25_raw_next;
      pm10_raw      <= pm10_raw_next;
      frame_done    <= frame_done_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_status <= status_next;
      out_pm25   <= pm25_next;
      out_pm10   <= pm10_next;
    end
  end

  // position never runs past the longer frame
  `PSFP_ASSERT_NOW(a_pos_range, clk, rst, 1'b1, byte_position <= LEN_LONG)
  // a reported frame leaves the position at one of the frame ends
  `PSFP_ASSERT_NOW(a_done_pos, clk, rst, frame_done,
    byte_position == LEN_LONG || byte_position == LEN_SHORT)
  // input stalls only behind a held result
  `PSFP_ASSERT_NOW(a_stall_cause, clk, rst, !in_ch.ready, out_valid && !out_ch.ready)
  // readings are zero on any error status
  `PSFP_ASSERT_NOW(a_err_zero, clk, rst, out_valid && out_status != STATUS_OK,
    out_pm25 == '0 && out_pm10 == '0)
  // a completed frame shows up in the output register next cycle
  `PSFP_ASSERT_NEXT(a_emit_valid, clk, rst, in_fire && emit, out_valid)

endmodule
